// File: hdl/tpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_pkg: shared constants and helpers for the tolerance palette builder
// Field widths of the pixel and result items and the per-channel match test.
// ----------------------------------------------------------------------------
package tpb_pkg;

  // one color channel
  localparam int unsigned ChanW   = 8;
  // packed pixel: red, green, blue from the lowest bit up
  localparam int unsigned PixW    = 3 * ChanW;
  // result index as seen on the output bus
  localparam int unsigned IndexW  = 8;
  // result flags: entry_added, palette_overflow
  localparam int unsigned FlagW   = 2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0]  pix_t;

  // true when |a - b| <= tol
  function automatic logic chan_near(chan_t a, chan_t b, chan_t tol);
    chan_t diff;
    begin
      diff = (a > b) ? (a - b) : (b - a);
      chan_near = (diff <= tol);
    end
  endfunction

  // all three channels of two packed pixels lie within tol
  function automatic logic pix_near(pix_t a, pix_t b, chan_t tol);
    begin
      pix_near = chan_near(a[ChanW-1:0], b[ChanW-1:0], tol) &&
                 chan_near(a[2*ChanW-1:ChanW], b[2*ChanW-1:ChanW], tol) &&
                 chan_near(a[3*ChanW-1:2*ChanW], b[3*ChanW-1:2*ChanW], tol);
    end
  endfunction

endpackage

// File: hdl/tolerance_palette_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_palette_builder_core: first-fit palette builder
// Maps each RGB pixel to the first stored palette entry within tolerance,
// appending the color as a new entry on a miss.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one pixel item per handshake, tdata = {blue, green, red},
//   tuser = start_of_image (clears the palette before the pixel is handled).
//   m_axis: one result item per pixel, tdata = palette_index,
//   tuser = {palette_overflow, entry_added}.
//   cfg: tolerance register write, always ready; write only while idle.
// Flow:
//   One pixel at a time. The scan reads one palette entry per cycle from
//   a single-port palette RAM and feeds one shared three-channel compare.
//   A hit ends the scan at the first matching entry; a miss tests every
//   stored entry, then appends the color or, on a full palette, flags an
//   overflow. The core returns to idle once the result is taken, and only
//   then accepts the next pixel.
// Reset:
//   Clears the entry count and tolerance; palette RAM is not cleared, only
//   entries below the count are ever read.
// Stall:
//   The result is held on m_axis until taken; s_axis stays not ready.
// ----------------------------------------------------------------------------
module tolerance_palette_builder_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tpb_pkg::PixW-1:0]      s_axis_tdata,   // red, green, blue
  input  logic                          s_axis_tuser,   // start_of_image
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tpb_pkg::IndexW-1:0]    m_axis_tdata,   // palette_index
  output logic [tpb_pkg::FlagW-1:0]     m_axis_tuser,   // entry_added, palette_overflow
  // tolerance register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpb_pkg::ChanW-1:0]     cfg_data_i
);

  import tpb_pkg::*;

  localparam int unsigned IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(PALETTE_ENTRIES);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;        // valid palette entries
  logic [CntW-1:0] rd_addr_q, rd_addr_d; // next entry to read
  logic            cmp_vld_q, cmp_vld_d; // rd_data_q holds an entry to test
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d; // index of that entry
  pix_t            pix_q, pix_d;
  chan_t           tol_q;
  logic [IdxW-1:0] res_idx_q, res_idx_d;
  logic            res_add_q, res_add_d;
  logic            res_ovf_q, res_ovf_d;

  pix_t            palette_mem [PALETTE_ENTRIES];
  pix_t            rd_data_q;
  logic            mem_we;
  logic            mem_re;
  logic            in_acc;
  logic            issue;
  logic            hit;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign issue  = (rd_addr_q < cnt_q);
  assign hit    = cmp_vld_q && pix_near(rd_data_q, pix_q, tol_q);

  // sequencer: scan, compare, decide
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_addr_d = rd_addr_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    pix_d     = pix_q;
    res_idx_d = res_idx_q;
    res_add_d = res_add_q;
    res_ovf_d = res_ovf_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pix_d     = s_axis_tdata;
          rd_addr_d = '0;
          cmp_vld_d = 1'b0;
          if (s_axis_tuser) begin
            cnt_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one entry per cycle
        cmp_vld_d = issue;
        if (issue) begin
          mem_re    = 1'b1;
          rd_addr_d = rd_addr_q + 1'b1;
          cmp_idx_d = rd_addr_q[IdxW-1:0];
        end
        if (hit) begin
          res_idx_d = cmp_idx_q;
          res_add_d = 1'b0;
          res_ovf_d = 1'b0;
          state_d   = ST_OUT;
        end else if (!cmp_vld_q && !issue) begin
          // every stored entry tested without a match
          if (cnt_q == CntFull) begin
            res_idx_d = '0;
            res_add_d = 1'b0;
            res_ovf_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            res_idx_d = cnt_q[IdxW-1:0];
            res_add_d = 1'b1;
            res_ovf_d = 1'b0;
            cnt_d     = cnt_q + 1'b1;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      cmp_vld_q <= 1'b0;
      tol_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_addr_q <= rd_addr_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    pix_q     <= pix_d;
    res_idx_q <= res_idx_d;
    res_add_q <= res_add_d;
    res_ovf_q <= res_ovf_d;
  end

  // palette RAM: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[cnt_q[IdxW-1:0]] <= pix_q;
    end
    if (mem_re) begin
      rd_data_q <= palette_mem[rd_addr_q[IdxW-1:0]];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = IndexW'(res_idx_q);
  assign m_axis_tuser  = {res_ovf_q, res_add_q};
  assign cfg_ready_o   = 1'b1;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count beyond palette size");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("entry added and overflow together");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (cnt_q == CntFull && m_axis_tdata == '0))
    else $error("overflow without a full palette");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (cnt_q == CntW'(res_idx_q) + 1'b1))
    else $error("added index does not match entry count");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

endmodule

// File: tb/tolerance_palette_builder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_palette_builder_core_tb: self-checking bench for the palette core
// Drives pixel items through a short table of directed cases, then through
// random images at several tolerance settings, filling the palette past its
// capacity. Each result is checked against the local first-fit model or a typed row's want.
// ----------------------------------------------------------------------------
module tolerance_palette_builder_core_tb;

  import tpb_pkg::*;

  localparam int unsigned PAL_DEPTH   = 256;
  localparam int          NO_TOL_WR   = -1;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned NUM_PHASES  = 8;

  // result of one pixel: index plus the two flags
  typedef struct packed {
    logic [7:0] idx;
    logic       added;
    logic       ovf;
  } pal_result_t;

  // one directed row; tol_wr >= 0 writes the tolerance before the pixel
  typedef struct {
    int          tol_wr;
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    logic        sof;
    bit          typed;
    pal_result_t want;
  } pix_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red, green, blue
  logic        s_axis_tuser;   // start_of_image
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // palette_index
  logic [1:0]  m_axis_tuser;   // entry_added, palette_overflow
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  // local palette model
  logic [23:0]  pal_mem [PAL_DEPTH];
  int unsigned  entry_total;
  chan_t        tol_q;

  pal_result_t  pending_q [$];
  pix_row_t     directed_q [$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  stall_left;
  bit           jitter_on;

  tolerance_palette_builder_core #(
    .PALETTE_ENTRIES(PAL_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #2 clk_i = ~clk_i;

  function automatic int unsigned chan_diff(chan_t a, chan_t b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // first-fit search, append on miss, overflow when full
  function automatic pal_result_t match_or_append(chan_t r, chan_t g, chan_t b,
                                                  logic sof);
    pal_result_t res;
    int unsigned k;
    res = '0;
    if (sof) entry_total = 0;
    for (k = 0; k < entry_total; k++) begin
      if (chan_diff(pal_mem[k][23:16], r) <= tol_q &&
          chan_diff(pal_mem[k][15:8], g) <= tol_q &&
          chan_diff(pal_mem[k][7:0], b) <= tol_q) begin
        res.idx = k[7:0];
        return res;
      end
    end
    if (entry_total >= PAL_DEPTH) begin
      res.ovf = 1'b1;
      return res;
    end
    pal_mem[entry_total] = {r, g, b};
    res.idx   = entry_total[7:0];
    res.added = 1'b1;
    entry_total++;
    return res;
  endfunction

  // channel value close to c: within tol+1 either way, clamped
  function automatic chan_t near_chan(chan_t c, chan_t tol);
    int span;
    int v;
    span = int'(tol) + 1;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void check_field(string name, int unsigned exp_v,
                                      int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  function automatic void add_row(int tol_wr, chan_t r, chan_t g, chan_t b,
                                  logic sof, bit typed, int unsigned idx,
                                  logic added, logic ovf);
    pix_row_t row;
    row.tol_wr     = tol_wr;
    row.red        = r;
    row.green      = g;
    row.blue       = b;
    row.sof        = sof;
    row.typed      = typed;
    row.want.idx   = idx[7:0];
    row.want.added = added;
    row.want.ovf   = ovf;
    directed_q = {directed_q, row};
  endfunction

  // send one pixel item; starts and ends on a falling edge
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic sof, input bit typed,
                            input pal_result_t want);
    pal_result_t got;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, g, r};
    s_axis_tuser  = sof;
    do @(posedge clk_i); while (!s_axis_tready);
    got = match_or_append(r, g, b, sof);
    if (typed) got = want;
    pending_q = {pending_q, got};
    @(negedge clk_i);
  endtask

  // tolerance write once all results are back and the core has settled
  task automatic set_tolerance(input chan_t v);
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_q = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result side backpressure in short bursts
  always @(negedge clk_i) begin
    if (!jitter_on) begin
      m_axis_tready = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pal_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        $error("result item with no pixel pending: index %0d", m_axis_tdata);
      end else begin
        exp_r = pending_q.pop_front();
        check_field("palette_index", 32'(exp_r.idx), 32'(m_axis_tdata));
        check_field("entry_added", 32'(exp_r.added), 32'(m_axis_tuser[0]));
        check_field("palette_overflow", 32'(exp_r.ovf), 32'(m_axis_tuser[1]));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tolerance_palette_builder_core verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    pix_row_t    row;
    pal_result_t none;
    int unsigned ph;
    int unsigned n;
    int unsigned n_items;
    int unsigned pick;
    int unsigned k;
    chan_t       tol_v;
    chan_t       r;
    chan_t       g;
    chan_t       b;
    logic        sof;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    entry_total    = 0;
    tol_q          = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    jitter_on      = 1'b1;
    none           = '0;

    // tolerance 0 from reset: empty palette, extremes, exact hits
    add_row(NO_TOL_WR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 0, 1'b1, 1'b0);
    add_row(NO_TOL_WR, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 1, 1'b1, 1'b0);
    add_row(NO_TOL_WR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 1, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'haa, 8'h55, 8'haa, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'h55, 8'haa, 8'h55, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    // start of image clears, then the pixel lands at index 0
    add_row(NO_TOL_WR, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 0, 1'b1, 1'b0);
    add_row(NO_TOL_WR, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    // tolerance 16: differences of exactly 16 on each channel and 17 on one
    add_row(16, 8'd100, 8'd100, 8'd100, 1'b1, 1'b1, 0, 1'b1, 1'b0);
    add_row(NO_TOL_WR, 8'd116, 8'd84, 8'd116, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'd117, 8'd100, 8'd100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'd100, 8'd100, 8'd83, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'd130, 8'd101, 8'd99, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    // tolerance 255: everything lands at entry 0; the start of image adds it anew
    add_row(255, 8'h80, 8'h80, 8'h80, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'hff, 8'h00, 8'hff, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    add_row(NO_TOL_WR, 8'h01, 8'h02, 8'h03, 1'b1, 1'b1, 0, 1'b1, 1'b0);
    add_row(NO_TOL_WR, 8'hfe, 8'hfd, 8'hfc, 1'b0, 1'b1, 0, 1'b0, 1'b0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.tol_wr != NO_TOL_WR) set_tolerance(row.tol_wr[7:0]);
      send_pixel(row.red, row.green, row.blue, row.sof, row.typed, row.want);
    end

    // random images, one tolerance per phase; the first phase overfills
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0, 6:    tol_v = 8'd0;
        1:       tol_v = 8'd255;
        2:       tol_v = 8'd1;
        3:       tol_v = 8'($urandom_range(2, 12));
        4:       tol_v = 8'($urandom_range(13, 64));
        5:       tol_v = 8'($urandom_range(0, 255));
        default: tol_v = 8'($urandom_range(0, 8));
      endcase
      n_items = (ph == 0) ? 320 : 115;
      set_tolerance(tol_v);
      // the final phase runs without any bubbles
      jitter_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < n_items; n++) begin
        sof  = (n == 0) || (ph != 0 && $urandom_range(0, 63) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 55 && entry_total != 0 && !sof) begin
          // near a stored color, often on the tolerance edge
          k = $urandom_range(0, entry_total - 1);
          r = near_chan(pal_mem[k][23:16], tol_q);
          g = near_chan(pal_mem[k][15:8], tol_q);
          b = near_chan(pal_mem[k][7:0], tol_q);
        end else if (pick < 65) begin
          r = $urandom_range(0, 1) ? 8'hff : 8'h00;
          g = $urandom_range(0, 1) ? 8'hff : 8'h00;
          b = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        send_pixel(r, g, b, sof, 1'b0, none);
      end
    end

    // drain and let the core settle
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (PAL_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tolerance_palette_builder_core verification clean");
    end else begin
      $display("tolerance_palette_builder_core verification failed");
    end
    $finish;
  end

endmodule

// File: tolerance_palette_builder_core.f
hdl/tpb_pkg.sv
hdl/tolerance_palette_builder_core.sv
tb/tolerance_palette_builder_core_tb.sv
